// ===== hdl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the base64 stream encoder
// Holds the command word passed from front to back, the queue status,
// the queue depth and the 6-bit symbol to ASCII alphabet mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // ASCII '=' used for padding
  localparam logic [6:0] PadChar = 7'h3D;

  // One encoding command: up to two symbols, then padding up to last_slot
  typedef struct packed {
    logic [5:0] sym0;      // first 6-bit symbol
    logic [5:0] sym1;      // second 6-bit symbol, used when two_sym is set
    logic       two_sym;   // slot one carries sym1 (else padding)
    logic [1:0] last_slot; // index of the final character of this command
    logic       eom;       // final character closes the message
  } b64e_cmd_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             empty;
    logic             full;
  } b64e_qstat_t;

  // Map a 6-bit symbol onto the standard alphabet
  function automatic logic [6:0] sym_char(input logic [5:0] s);
    logic [6:0] s7;
    s7 = {1'b0, s};
    case (s) inside
      [6'd0:6'd25]:  sym_char = s7 + 7'h41;  // 'A'..'Z'
      [6'd26:6'd51]: sym_char = s7 + 7'h47;  // 'a'..'z'
      [6'd52:6'd61]: sym_char = s7 - 7'd4;   // '0'..'9'
      6'd62:         sym_char = 7'h2B;       // '+'
      default:       sym_char = 7'h2F;       // '/'
    endcase
  endfunction

endpackage

// ===== hdl/base64_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_top: streaming base64 encoder
// A byte accepted on the input is written into the command queue; its first
//   character then moves into the out_tvalid output register once that is free.
// Throughput: one character per cycle at the output register while out_tready
//   is high; a byte yields one or two characters, two to four if it is last.
// Reset (rst_n low, synchronous): group state, queue and output valid clear.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] char_code, [7] zero
  output logic       out_tlast   // end_of_output
);

  b64e_pkg::b64e_cmd_t   push_cmd;
  b64e_pkg::b64e_cmd_t   head;
  b64e_pkg::b64e_qstat_t qstat;
  logic                  push;
  logic                  pop;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Queue never holds more than its depth
  a_qcount: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= b64e_pkg::QCntW'(b64e_pkg::QDepth))
    else $error("command queue overfilled");

  // Never pop an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty command queue");

  // With nothing queued, a drained output stays empty
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.empty && (!out_tvalid || out_tready)) |=> !out_tvalid)
    else $error("character produced with no pending command");

endmodule

// ===== hdl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front: byte intake and group tracking
// Accepts one byte per cycle while the queue has room, tracks the position
// in the 3-byte group and leftover bits, and issues one command word per byte.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // end_of_message
  input  b64e_pkg::b64e_qstat_t qstat,
  output logic                  push,
  output b64e_pkg::b64e_cmd_t   push_cmd
);

  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhOne   = 2'd1;
  localparam logic [1:0] PhTwo   = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [5:0] left_r, left_nxt;
  logic [1:0] phase_eff;
  logic [5:0] left_new;
  logic [1:0] phase_new;

  // Accept while the queue has room
  assign in_tready = !qstat.full;
  assign push      = in_tvalid && in_tready;

  // Treat the unused phase code as the start of a group
  assign phase_eff = (phase_r inside {PhStart, PhOne, PhTwo}) ? phase_r : PhStart;

  // Split the byte into symbols and leftover bits
  always_comb begin
    push_cmd = '0;
    push_cmd.eom = in_tlast;
    case (phase_eff)
      PhOne: begin
        push_cmd.sym0      = left_r | {2'b00, in_tdata[7:4]};
        left_new           = {in_tdata[3:0], 2'b00};
        push_cmd.sym1      = left_new;
        push_cmd.two_sym   = in_tlast;
        push_cmd.last_slot = in_tlast ? 2'd2 : 2'd0;
        phase_new          = PhTwo;
      end
      PhTwo: begin
        push_cmd.sym0      = left_r | {4'b0000, in_tdata[7:6]};
        push_cmd.sym1      = in_tdata[5:0];
        left_new           = 6'd0;
        push_cmd.two_sym   = 1'b1;
        push_cmd.last_slot = 2'd1;
        phase_new          = PhStart;
      end
      default: begin
        push_cmd.sym0      = in_tdata[7:2];
        left_new           = {in_tdata[1:0], 4'b0000};
        push_cmd.sym1      = left_new;
        push_cmd.two_sym   = in_tlast;
        push_cmd.last_slot = in_tlast ? 2'd3 : 2'd0;
        phase_new          = PhOne;
      end
    endcase
  end

  // Advance the group state; the last byte returns to the start
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    if (push) begin
      phase_nxt = in_tlast ? PhStart : phase_new;
      left_nxt  = in_tlast ? 6'd0 : left_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhStart;
      left_r  <= 6'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== hdl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue: command queue between front and back
// Small register FIFO; the head entry is read at the read pointer.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64e_pkg::b64e_cmd_t   push_cmd,
  input  logic                  pop,
  output b64e_pkg::b64e_cmd_t   head,
  output b64e_pkg::b64e_qstat_t qstat
);

  b64e_pkg::b64e_cmd_t             mem_r [b64e_pkg::QDepth];
  logic [b64e_pkg::QPtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [b64e_pkg::QPtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [b64e_pkg::QCntW-1:0]      count_r, count_nxt;

  assign head        = mem_r[rd_ptr_r];
  assign qstat.count = count_r;
  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == b64e_pkg::QCntW'(b64e_pkg::QDepth));

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back: character serializer
// Walks the slots of the head command, one character per cycle while output
// is taken, maps symbols onto the alphabet, holds each in an output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64e_pkg::b64e_cmd_t   head,
  input  b64e_pkg::b64e_qstat_t qstat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [6:0] char_code, [7] zero
  output logic                  out_tlast   // end_of_output
);

  logic [1:0] slot_r, slot_nxt;
  logic       valid_r, valid_nxt;
  logic [6:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       load, emit, final_slot;

  // Output register is free when empty or being taken
  assign load       = !valid_r || out_tready;
  assign emit       = load && !qstat.empty;
  assign final_slot = (slot_r == head.last_slot);
  assign pop        = emit && final_slot;

  // Pick the character of the current slot
  always_comb begin
    if (slot_r == 2'd0) begin
      char_nxt = b64e_pkg::sym_char(head.sym0);
    end else if (slot_r == 2'd1 && head.two_sym) begin
      char_nxt = b64e_pkg::sym_char(head.sym1);
    end else begin
      char_nxt = b64e_pkg::PadChar;
    end
    last_nxt  = final_slot && head.eom;
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    if (emit) begin
      slot_nxt  = final_slot ? 2'd0 : slot_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Hold the word until taken
  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, char_r};
  assign out_tlast  = last_r;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the base64 stream encoder
// Drives byte words with an end-of-message flag on the input stream and
// checks every character word on the output stream against typed
// characters or a local encoder model. A short table of directed bytes
// comes first, then random messages. Both sides idle at random, and once
// the receiver holds off long enough to back the encoder up into its input.
// ----------------------------------------------------------------------------
module tb_top;

  // Standard alphabet, symbol 0 in the top byte
  localparam logic [8*64-1:0] Base64Digits =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int RandomBytes = 305;
  localparam int DirRows     = 23;
  localparam int HoldCycles  = 80;
  localparam int HoldAfter   = 250;
  localparam int MaxPrinted  = 30;

  // One expected output word
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } b64_char_t;

  // One directed row; chars holds nchk typed characters, zero means model only
  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic [2:0]  nchk;
    logic [31:0] chars;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // Encoder model state
  logic [1:0] grp_phase = 2'd0;
  logic [5:0] carry_bits = 6'd0;

  b64_char_t pending_chars[$];
  dir_row_t  dir_table [DirRows];

  int  err_count = 0;
  int  bytes_sent = 0;
  int  msgs_sent = 0;
  int  chars_seen = 0;
  int  in_stalls = 0;
  bit  steady = 1'b0;
  bit  hold_done = 1'b0;

  base64_stream_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tlast   (in_tlast),   // end_of_message
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [6:0] char_code, [7] zero
    .out_tlast  (out_tlast)   // end_of_output
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Count cycles where the encoder pushes back on a waiting byte
  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) begin
      in_stalls++;
    end
  end

  function automatic logic [6:0] b64_char(input logic [5:0] s);
    return Base64Digits[8 * (63 - int'(s)) +: 7];
  endfunction

  // Advance the encoder model by one byte; return the number of characters
  function automatic int encode_byte(input logic [7:0] b, input logic eom,
                                     output logic [3:0][6:0] syms);
    int n;
    n = 0;
    syms = '0;
    case (grp_phase)
      2'd1: begin
        syms[0] = b64_char(carry_bits | {2'b00, b[7:4]});
        carry_bits = {b[3:0], 2'b00};
        grp_phase = 2'd2;
        n = 1;
        if (eom) begin
          syms[1] = b64_char(carry_bits);
          syms[2] = b64e_pkg::PadChar;
          n = 3;
        end
      end
      2'd2: begin
        syms[0] = b64_char(carry_bits | {4'b0000, b[7:6]});
        syms[1] = b64_char(b[5:0]);
        carry_bits = 6'd0;
        grp_phase = 2'd0;
        n = 2;
      end
      default: begin
        // start of a group; the unused phase three counts as a start too
        syms[0] = b64_char(b[7:2]);
        carry_bits = {b[1:0], 4'b0000};
        grp_phase = 2'd1;
        n = 1;
        if (eom) begin
          syms[1] = b64_char(carry_bits);
          syms[2] = b64e_pkg::PadChar;
          syms[3] = b64e_pkg::PadChar;
          n = 4;
        end
      end
    endcase
    if (eom) begin
      grp_phase = 2'd0;
      carry_bits = 6'd0;
    end
    return n;
  endfunction

  task automatic flag_error(input string msg);
    // print the first few, count them all
    if (err_count < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Offer one byte word, wait for the handshake, then queue its characters
  task automatic send_byte(input logic [7:0] b, input logic eom,
                           input logic [31:0] typed, input int ntyped);
    int gap;
    int n;
    logic [3:0][6:0] syms;
    b64_char_t c;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eom;
    do @(posedge clk); while (!in_tready);
    n = encode_byte(b, eom, syms);
    if (ntyped > 0) begin
      for (int k = 0; k < ntyped; k++) begin
        c.code = typed[8 * (ntyped - 1 - k) +: 7];
        c.last = eom && (k == ntyped - 1);
        pending_chars.push_back(c);
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        c.code = syms[k];
        c.last = eom && (k == n - 1);
        pending_chars.push_back(c);
      end
    end
    bytes_sent++;
    if (eom) begin
      msgs_sent++;
    end
  endtask

  // Compare an accepted character word with the oldest expectation
  task automatic check_char();
    b64_char_t want;
    chars_seen++;
    if (pending_chars.size() == 0) begin
      flag_error($sformatf("unexpected char 0x%02h last %0b", out_tdata, out_tlast));
    end else begin
      want = pending_chars.pop_front();
      if (out_tdata[6:0] !== want.code) begin
        flag_error($sformatf("char %0d: got 0x%02h want 0x%02h",
                             chars_seen, out_tdata[6:0], want.code));
      end
      if (out_tdata[7] !== 1'b0) begin
        flag_error($sformatf("char %0d: fill bit set", chars_seen));
      end
      if (out_tlast !== want.last) begin
        flag_error($sformatf("char %0d: last %0b want %0b",
                             chars_seen, out_tlast, want.last));
      end
    end
  endtask

  // Receiver: random back-pressure, one long hold-off partway through
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (!hold_done && chars_seen >= HoldAfter) begin
        gap = HoldCycles;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_char();
    end
  end

  // Stimulus: reset, directed table, random messages, drain
  initial begin
    int msg_len;
    int pick;
    logic [7:0] b;

    // typed rows: single bytes, full groups, all-zero and all-one, '+' and '/'
    dir_table[0]  = '{8'h00, 1'b1, 3'd4, "AA=="};
    dir_table[1]  = '{8'hFF, 1'b1, 3'd4, "/w=="};
    dir_table[2]  = '{8'hFF, 1'b0, 3'd1, "/"};
    dir_table[3]  = '{8'hFF, 1'b1, 3'd3, "/8="};
    dir_table[4]  = '{8'hFF, 1'b0, 3'd1, "/"};
    dir_table[5]  = '{8'hFF, 1'b0, 3'd1, "/"};
    dir_table[6]  = '{8'hFF, 1'b1, 3'd2, "//"};
    dir_table[7]  = '{8'h00, 1'b0, 3'd1, "A"};
    dir_table[8]  = '{8'h00, 1'b0, 3'd1, "A"};
    dir_table[9]  = '{8'h00, 1'b1, 3'd2, "AA"};
    dir_table[10] = '{8'h4D, 1'b0, 3'd1, "T"};
    dir_table[11] = '{8'h61, 1'b0, 3'd1, "W"};
    dir_table[12] = '{8'h6E, 1'b1, 3'd2, "Fu"};
    dir_table[13] = '{8'hF8, 1'b1, 3'd4, "+A=="};
    // model-checked rows: single set or clear bits, alternating bits, other bytes
    dir_table[14] = '{8'h80, 1'b0, 3'd0, 32'h0};
    dir_table[15] = '{8'h01, 1'b1, 3'd0, 32'h0};
    dir_table[16] = '{8'h55, 1'b0, 3'd0, 32'h0};
    dir_table[17] = '{8'hAA, 1'b0, 3'd0, 32'h0};
    dir_table[18] = '{8'h7F, 1'b1, 3'd0, 32'h0};
    dir_table[19] = '{8'hFE, 1'b0, 3'd0, 32'h0};
    dir_table[20] = '{8'h01, 1'b0, 3'd0, 32'h0};
    dir_table[21] = '{8'hD3, 1'b0, 3'd0, 32'h0};
    dir_table[22] = '{8'h3C, 1'b1, 3'd0, 32'h0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (dir_table[i]) begin
      send_byte(dir_table[i].data, dir_table[i].eom, dir_table[i].chars,
                int'(dir_table[i].nchk));
    end

    // random whole messages; one stretch runs without idling
    while (bytes_sent < DirRows + RandomBytes) begin
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                            : $urandom_range(1, 10);
      for (int k = 0; k < msg_len; k++) begin
        steady = (bytes_sent >= 150) && (bytes_sent < 200);
        pick = $urandom_range(0, 7);
        b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        send_byte(b, k == msg_len - 1, 32'h0, 0);
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // drain, then allow a few cycles for any stray word
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Encoded %0d messages, %0d bytes; checked %0d characters.",
             msgs_sent, bytes_sent, chars_seen);
    $display("Input stalled %0d cycles under output back-pressure.", in_stalls);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Timed out with %0d characters outstanding.", pending_chars.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
